[rtl/core/sorted_priority_queue_top_assert.svh]
// Assertion macros for the sorted priority queue checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spq check failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spq check failed");

`endif

[rtl/core/spq_pkg.sv]
// Shared constants and types for the sorted priority queue.
// No dependencies.
package spq_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int COUNT_W = 5;
	localparam int STAT_W  = 2;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} spq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_pending;
		logic out_take;
	} spq_stat_t;

endpackage

[rtl/core/spq_if.sv]
// Request and response channel interfaces for the sorted priority queue.
// Depends on spq_pkg.
interface spq_req_if;
	logic                               valid;
	logic                               ready;
	logic                               mode;
	logic signed [spq_pkg::DATA_W-1:0]  in_value;

	modport source (output valid, output mode, output in_value, input ready);
	modport sink   (input valid, input mode, input in_value, output ready);
endinterface

interface spq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [spq_pkg::DATA_W-1:0]  out_value;
	logic        [spq_pkg::STAT_W-1:0]  status;
	logic        [spq_pkg::COUNT_W-1:0] count;
	logic                               is_empty;
	logic                               is_full;

	modport source (output valid, output out_value, output status, output count,
		output is_empty, output is_full, input ready);
	modport sink   (input valid, input out_value, input status, input count,
		input is_empty, input is_full, output ready);
endinterface

[rtl/core/sorted_priority_queue_top.sv]
// Top level of the max-first sorted priority queue.
// Depends on spq_pkg, spq_if, spq_ctrl and spq_dp.
//
//  channel | side | payload
//  --------+------+--------------------------------------------------
//  req     | in   | mode, in_value
//  rsp     | out  | out_value, status, count, is_empty, is_full
//
// Each item is accepted, then executed: an insert has all cells compare
// against the new value and shift in parallel; a remove shifts every cell up.
// The result register lets the next item be accepted while a result waits;
// the execute cycle holds until that register is free or being taken.
// Reset clears the entry count and the result valid; cell contents are
// not cleared, and no clearing pass is needed.
module sorted_priority_queue_top (
	input  logic         clk,
	input  logic         arst_n,
	spq_req_if.sink      req,
	spq_rsp_if.source    rsp
);

	spq_pkg::spq_cmd_t  cmd;
	spq_pkg::spq_stat_t stat;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	spq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_mode   (req.mode),
		.req_value  (req.in_value),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_value  (rsp.out_value),
		.rsp_status (rsp.status),
		.rsp_count  (rsp.count),
		.rsp_empty  (rsp.is_empty),
		.rsp_full   (rsp.is_full)
	);

endmodule

[rtl/core/spq_ctrl.sv]
// Sequencer for the sorted priority queue: accept, then execute one operation.
// Depends on spq_pkg.
module spq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  spq_pkg::spq_stat_t stat,
	output spq_pkg::spq_cmd_t  cmd
);

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_EXEC = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_nxt;
	logic       slot_free;

	// result register is free, or its transfer completes this cycle
	assign slot_free = !stat.out_pending || stat.out_take;

	always_comb begin
		state_nxt = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (slot_free) begin
					cmd.exec  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[rtl/core/spq_dp.sv]
// Datapath: sorted shift-register cells, entry count and result register.
// Depends on spq_pkg.
module spq_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spq_pkg::spq_cmd_t                  cmd,
	output spq_pkg::spq_stat_t                 stat,
	input  logic                               req_mode,
	input  logic signed [spq_pkg::DATA_W-1:0]  req_value,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic signed [spq_pkg::DATA_W-1:0]  rsp_value,
	output logic        [spq_pkg::STAT_W-1:0]  rsp_status,
	output logic        [spq_pkg::COUNT_W-1:0] rsp_count,
	output logic                               rsp_empty,
	output logic                               rsp_full
);

	localparam int D  = spq_pkg::DEPTH;
	localparam int DW = spq_pkg::DATA_W;
	localparam int CW = spq_pkg::CNT_W;

	logic                     mode_q;
	logic signed [DW-1:0]     value_q;
	logic signed [DW-1:0]     ent_q   [D];
	logic signed [DW-1:0]     ins_ent [D];
	logic signed [DW-1:0]     rem_ent [D];
	logic        [D-1:0]      keep;
	logic        [CW-1:0]     cnt_q;
	logic        [CW-1:0]     cnt_nxt;
	logic                     full;
	logic                     empty;
	logic                     do_ins;
	logic                     do_rem;
	logic        [spq_pkg::STAT_W-1:0] status_nxt;
	logic                     out_valid_q;
	logic signed [DW-1:0]     out_value_q;
	logic        [spq_pkg::STAT_W-1:0] out_status_q;
	logic        [CW-1:0]     out_cnt_q;

	assign full   = (cnt_q == CW'(D));
	assign empty  = (cnt_q == '0);
	assign do_ins = (mode_q == spq_pkg::MODE_INSERT) && !full;
	assign do_rem = (mode_q == spq_pkg::MODE_REMOVE) && !empty;

	// keep[i]: held entry i stays put because it is not below the new value;
	// sorted order makes keep a prefix
	for (genvar i = 0; i < D; i++) begin : g_cell
		assign keep[i] = (CW'(i) < cnt_q) && (ent_q[i] >= value_q);
		if (i == 0) begin : g_head
			assign ins_ent[i] = keep[i] ? ent_q[i] : value_q;
		end else begin : g_body
			assign ins_ent[i] = keep[i] ? ent_q[i] :
				(keep[i-1] ? value_q : ent_q[i-1]);
		end
		if (i == D - 1) begin : g_last
			assign rem_ent[i] = ent_q[i];
		end else begin : g_mid
			assign rem_ent[i] = ent_q[i+1];
		end
	end

	always_comb begin
		cnt_nxt    = cnt_q;
		status_nxt = spq_pkg::ST_DONE;
		if (mode_q == spq_pkg::MODE_INSERT) begin
			if (full) status_nxt = spq_pkg::ST_FULL;
			else      cnt_nxt    = cnt_q + CW'(1);
		end else begin
			if (empty) status_nxt = spq_pkg::ST_EMPTY;
			else       cnt_nxt    = cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= req_mode;
			value_q <= req_value;
		end
		if (cmd.exec) begin
			if (do_ins) ent_q <= ins_ent;
			else if (do_rem) ent_q <= rem_ent;
			out_value_q  <= do_rem ? ent_q[0] : '0;
			out_status_q <= status_nxt;
			out_cnt_q    <= cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) cnt_q <= cnt_nxt;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	assign stat.out_pending = out_valid_q;
	assign stat.out_take    = out_valid_q && rsp_ready;

	assign rsp_valid  = out_valid_q;
	assign rsp_value  = out_value_q;
	assign rsp_status = out_status_q;
	assign rsp_count  = spq_pkg::COUNT_W'(out_cnt_q);
	assign rsp_empty  = (out_cnt_q == '0);
	assign rsp_full   = (out_cnt_q == CW'(D));

endmodule

[rtl/core/spq_checker.sv]
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_top_assert.svh.
`include "sorted_priority_queue_top_assert.svh"

module spq_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic signed [spq_pkg::DATA_W-1:0]  out_value,
	input logic        [spq_pkg::STAT_W-1:0]  status,
	input logic        [spq_pkg::COUNT_W-1:0] count,
	input logic                               is_empty,
	input logic                               is_full
);

	// a refused operation never returns a value
	`SPQ_ASSERT_NOW(a_refused_zero, rsp_valid && status != spq_pkg::ST_DONE, out_value == '0)
	// flags agree with the count
	`SPQ_ASSERT_NOW(a_empty_flag, rsp_valid, is_empty == (count == '0))
	`SPQ_ASSERT_NOW(a_full_flag, rsp_valid, is_full == (count == spq_pkg::COUNT_W'(spq_pkg::DEPTH)))
	// a stalled result holds
	`SPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(out_value))

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.out_value (rsp.out_value),
	.status    (rsp.status),
	.count     (rsp.count),
	.is_empty  (rsp.is_empty),
	.is_full   (rsp.is_full)
);

[verif/tb_top.sv]
// Self-checking testbench for sorted_priority_queue_top: random and directed
// insert/remove traffic with a shadow sorted queue predicting every result.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and the queue RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	typedef logic signed [DATA_W-1:0] word_t;

	// Shadow copy of the queue plus the results it still owes.
	class queue_shadow;
		typedef struct {
			word_t              value;
			logic [STAT_W-1:0]  status;
			logic [COUNT_W-1:0] count;
			logic               empty;
			logic               full;
		} outcome_t;

		word_t       slots[DEPTH];
		int unsigned held;
		outcome_t    owed_q[$];
		int unsigned mismatches, results_seen;
		int unsigned inserts_done, removes_done, refused_full, refused_empty;

		function new();
			held = 0;
			mismatches = 0;
			results_seen = 0;
			inserts_done = 0;
			removes_done = 0;
			refused_full = 0;
			refused_empty = 0;
		endfunction

		// apply one accepted request and queue the outcome it must produce
		function void note_request(logic m, word_t v);
			outcome_t    o;
			int unsigned pos;
			o.value  = '0;
			o.status = ST_DONE;
			if (m == MODE_INSERT) begin
				if (held >= DEPTH) begin
					o.status = ST_FULL;
					refused_full++;
				end else begin
					// equal values stay ahead of the newcomer
					pos = held;
					while (pos > 0 && slots[pos-1] < v) begin
						slots[pos] = slots[pos-1];
						pos--;
					end
					slots[pos] = v;
					held++;
					inserts_done++;
				end
			end else begin
				if (held == 0) begin
					o.status = ST_EMPTY;
					refused_empty++;
				end else begin
					o.value = slots[0];
					for (int i = 1; i < held; i++)
						slots[i-1] = slots[i];
					held--;
					removes_done++;
				end
			end
			o.count = held[COUNT_W-1:0];
			o.empty = (held == 0);
			o.full  = (held >= DEPTH);
			owed_q.push_back(o);
		endfunction

		function void check_result(word_t value, logic [STAT_W-1:0] status,
			logic [COUNT_W-1:0] count, logic empty, logic full);
			outcome_t o;
			results_seen++;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing outstanding: value=%0d status=%0d",
						$realtime, value, status);
				return;
			end
			o = owed_q.pop_front();
			if (value !== o.value || status !== o.status || count !== o.count ||
				empty !== o.empty || full !== o.full) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch exp value=%0d status=%0d count=%0d empty=%0b full=%0b",
						$realtime, o.value, o.status, o.count, o.empty, o.full);
					$display("%0t:          got value=%0d status=%0d count=%0d empty=%0b full=%0b",
						$realtime, value, status, count, empty, full);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	spq_req_if req ();
	spq_rsp_if rsp ();

	sorted_priority_queue_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	queue_shadow shadow = new();
	bit          sender_quiet = 0;

	always #2 clk = ~clk;

	function automatic word_t draw_value();
		word_t v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v = $urandom;
			5, 6:          v = int'($urandom_range(0, 8)) - 4;
			7: begin
				case ($urandom_range(0, 5))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'h7FFF_FFFE;
					3: v = 32'h8000_0001;
					4: v = 0;
					default: v = -1;
				endcase
			end
			default: v = int'($urandom_range(0, 2000)) - 1000;
		endcase
		return v;
	endfunction

	// offer one request, hold it until transfer; valid stays up if no gap follows
	task automatic push_request(input logic m, input word_t v);
		int unsigned gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid    <= 1'b1;
		req.mode     <= m;
		req.in_value <= v;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		shadow.note_request(m, v);
	endtask

	// response side: random back-pressure plus one long hold-off
	initial begin : drain
		int unsigned gap;
		int unsigned quiet_left;
		bit          quiet;
		bit          held_off;
		quiet_left = 0;
		quiet      = 0;
		held_off   = 0;
		rsp.ready  = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && shadow.results_seen >= 120) begin
				held_off = 1;
				gap = 150;
			end else begin
				if (quiet_left == 0) begin
					quiet      = ($urandom_range(0, 3) == 0);
					quiet_left = $urandom_range(20, 60);
				end
				quiet_left--;
				gap = quiet ? 0 : $urandom_range(0, 16);
			end
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
			shadow.check_result(rsp.out_value, rsp.status, rsp.count,
				rsp.is_empty, rsp.is_full);
		end
	end

	initial begin : stimulus
		int unsigned sent_random;
		int unsigned seg_len;
		int unsigned insert_pct;
		logic        m;
		word_t       fill_vals[DEPTH];
		clk          = 1'b0;
		arst_n       = 1'b0;
		req.valid    = 1'b0;
		req.mode     = MODE_INSERT;
		req.in_value = '0;
		fill_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 0, -1, 1, 5, 5, 5, -5,
			32'h4000_0000, 32'hC000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 7, -7,
			32'h7FFF_FFFF};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: remove on empty, fill with extremes and duplicates,
		// insert on full, then a couple of removals and a refill
		push_request(MODE_REMOVE, 32'h1234_5678);
		foreach (fill_vals[i])
			push_request(MODE_INSERT, fill_vals[i]);
		push_request(MODE_INSERT, 3);
		push_request(MODE_REMOVE, 0);
		push_request(MODE_REMOVE, -1);
		push_request(MODE_INSERT, 32'h8000_0000);

		// random segments swing between filling, draining and balanced mixes
		sent_random = 0;
		while (sent_random < 550) begin
			seg_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0:       insert_pct = 85;
				1:       insert_pct = 50;
				default: insert_pct = 15;
			endcase
			sender_quiet = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < seg_len && sent_random < 550; k++) begin
				m = ($urandom_range(1, 100) <= insert_pct) ? MODE_INSERT : MODE_REMOVE;
				push_request(m, draw_value());
				sent_random++;
			end
		end
		req.valid <= 1'b0;

		while (shadow.owed_q.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d inserts, %0d removals, %0d refused while full,",
			shadow.inserts_done, shadow.removes_done, shadow.refused_full);
		$display("%0d refused while empty; %0d results checked, %0d mismatches",
			shadow.refused_empty, shadow.results_seen, shadow.mismatches);
		if (shadow.mismatches == 0 && shadow.owed_q.size() == 0)
			$display("[sorted_priority_queue_top] OK");
		else
			$display("[sorted_priority_queue_top] ERROR");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("[sorted_priority_queue_top] ERROR");
		$finish;
	end
endmodule
